// File: design/wkq_pkg.sv
// wkq_pkg: shared types, codes and sizes for the watchdog kick qualifier.
// Used by every module in design/; depends on nothing.
package wkq_pkg;

	localparam int GUARD_SLOTS = 8;
	localparam int SLOT_W      = 3;
	localparam int TIME_W      = 32;
	localparam int DEPTH_W     = 8;

	localparam logic [TIME_W-1:0]  MAX_BUDGET_RST = 32'd60000;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX      = 8'd255;

	typedef enum logic [2:0] {
		KIND_STARTUP  = 3'd0,
		KIND_MAIN     = 3'd1,
		KIND_VM       = 3'd2,
		KIND_OPEN     = 3'd3,
		KIND_PROGRESS = 3'd4,
		KIND_CLOSE    = 3'd5
	} kind_t;

	typedef struct packed {
		logic arm;
		logic clear;
		logic touch;
	} slot_cmd_t;

	typedef struct packed {
		logic active;
		logic pending;
		logic moved;
	} slot_stat_t;

endpackage

// File: design/watchdog_kick_qualifier_core.sv
// watchdog_kick_qualifier_core: top level; input register, event decode,
// depth counter and result register. Depends on wkq_pkg, wkq_progress, wkq_slot_bank.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  command  | start / busy        | kind, now_ms, budget, slot
//  result   | done (1-cycle)      | kick, guard_ok, open_guards
//  config   | cfg_we              | cfg_wdata (max_budget_ms)
//
// One item per cycle; the result strobes once the item has passed the input
// register, then decode into the result register. busy is always low.
// Async reset clears all control state, depth and max_budget_ms to 60000.
// The receiver cannot stall; done lasts exactly one cycle.
module watchdog_kick_qualifier_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   kind,
	input  logic [wkq_pkg::TIME_W-1:0]   now_ms,
	input  logic [wkq_pkg::TIME_W-1:0]   budget,
	input  logic [wkq_pkg::SLOT_W-1:0]   slot,
	output logic                         done,
	output logic                         kick,
	output logic                         guard_ok,
	output logic [wkq_pkg::DEPTH_W-1:0]  open_guards,
	input  logic                         cfg_we,
	input  logic [wkq_pkg::TIME_W-1:0]   cfg_wdata
);

	logic                        valid_s1;
	logic [2:0]                  kind_s1;
	logic [wkq_pkg::TIME_W-1:0]  now_s1;
	logic [wkq_pkg::TIME_W-1:0]  budget_s1;
	logic [wkq_pkg::SLOT_W-1:0]  slot_s1;

	logic [wkq_pkg::TIME_W-1:0]  max_budget_q;
	logic [wkq_pkg::DEPTH_W-1:0] depth_q;
	logic                        done_q;
	logic                        kick_q;
	logic                        guard_ok_q;

	wkq_pkg::slot_cmd_t          slot_cmd;
	wkq_pkg::slot_stat_t         slot_stat;
	logic                        slot_ok;
	logic                        budget_ok;
	logic                        depth_zero;
	logic                        main_upd;
	logic                        vm_upd;
	logic                        main_moved;
	logic                        vm_moved;
	logic                        kick_d;
	logic                        ok_d;
	logic [wkq_pkg::DEPTH_W-1:0] depth_d;

	assign busy        = 1'b0;
	assign done        = done_q;
	assign kick        = kick_q;
	assign guard_ok    = guard_ok_q;
	assign open_guards = depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1   <= kind;
			now_s1    <= now_ms;
			budget_s1 <= budget;
			slot_s1   <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_budget_q <= wkq_pkg::MAX_BUDGET_RST;
		end else if (cfg_we) begin
			max_budget_q <= cfg_wdata;
		end
	end

	assign slot_ok    = 7'(slot_s1) < 7'(wkq_pkg::GUARD_SLOTS);
	assign budget_ok  = (budget_s1 != '0) && (budget_s1 <= max_budget_q);
	assign depth_zero = depth_q == '0;

	always_comb begin
		kick_d   = 1'b0;
		ok_d     = 1'b0;
		depth_d  = depth_q;
		main_upd = 1'b0;
		vm_upd   = 1'b0;
		slot_cmd = '0;
		if (valid_s1) begin
			unique case (kind_s1)
				wkq_pkg::KIND_STARTUP: begin
					kick_d = 1'b1;
				end
				wkq_pkg::KIND_MAIN: begin
					main_upd = depth_zero;
					kick_d   = depth_zero && main_moved;
				end
				wkq_pkg::KIND_VM: begin
					vm_upd = depth_zero;
					kick_d = depth_zero && vm_moved;
				end
				wkq_pkg::KIND_OPEN: begin
					if (slot_ok) begin
						slot_cmd.clear = 1'b1;
						if (budget_ok) begin
							slot_cmd.arm = 1'b1;
							kick_d       = 1'b1;
							if (depth_q != wkq_pkg::DEPTH_MAX) begin
								depth_d = depth_q + 1'b1;
							end
						end
					end
				end
				wkq_pkg::KIND_PROGRESS: begin
					if (slot_ok && slot_stat.active && !depth_zero && slot_stat.pending) begin
						ok_d           = 1'b1;
						kick_d         = slot_stat.moved;
						slot_cmd.touch = slot_stat.moved;
					end
				end
				wkq_pkg::KIND_CLOSE: begin
					if (slot_ok && slot_stat.active) begin
						slot_cmd.clear = 1'b1;
						if (!depth_zero) begin
							depth_d = depth_q - 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			kick_q     <= 1'b0;
			guard_ok_q <= 1'b0;
			depth_q    <= '0;
		end else begin
			done_q     <= valid_s1;
			kick_q     <= kick_d;
			guard_ok_q <= ok_d;
			depth_q    <= depth_d;
		end
	end

	wkq_progress u_main (
		.clk    (clk),
		.arst_n (arst_n),
		.update (main_upd),
		.now_ms (now_s1),
		.moved  (main_moved)
	);

	wkq_progress u_vm (
		.clk    (clk),
		.arst_n (arst_n),
		.update (vm_upd),
		.now_ms (now_s1),
		.moved  (vm_moved)
	);

	wkq_slot_bank u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (slot_cmd),
		.slot   (slot_s1),
		.now_ms (now_s1),
		.budget (budget_s1),
		.stat   (slot_stat)
	);

endmodule

// File: design/wkq_progress.sv
// wkq_progress: last-seen time tracker for one progress source (main or vm).
// Depends on wkq_pkg.
module wkq_progress (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        update,
	input  logic [wkq_pkg::TIME_W-1:0]  now_ms,
	output logic                        moved
);

	logic                       seen_q;
	logic [wkq_pkg::TIME_W-1:0] last_q;

	assign moved = !seen_q || (now_ms != last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_q <= '0;
		end else if (update && moved) begin
			seen_q <= 1'b1;
			last_q <= now_ms;
		end
	end

endmodule

// File: design/wkq_slot_bank.sv
// wkq_slot_bank: guard slot storage (active bits, deadlines, last times)
// and the per-slot status compares. Depends on wkq_pkg.
module wkq_slot_bank (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wkq_pkg::slot_cmd_t          cmd,
	input  logic [wkq_pkg::SLOT_W-1:0]  slot,
	input  logic [wkq_pkg::TIME_W-1:0]  now_ms,
	input  logic [wkq_pkg::TIME_W-1:0]  budget,
	output wkq_pkg::slot_stat_t         stat
);

	logic                       active_q   [wkq_pkg::GUARD_SLOTS];
	logic [wkq_pkg::TIME_W-1:0] deadline_q [wkq_pkg::GUARD_SLOTS];
	logic [wkq_pkg::TIME_W-1:0] last_q     [wkq_pkg::GUARD_SLOTS];
	logic [wkq_pkg::TIME_W-1:0] remain;

	// deadline still ahead while the wrapped difference is non-negative
	assign remain       = deadline_q[slot] - now_ms;
	assign stat.active  = active_q[slot];
	assign stat.pending = !remain[wkq_pkg::TIME_W-1];
	assign stat.moved   = now_ms != last_q[slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wkq_pkg::GUARD_SLOTS; i++) begin
				active_q[i] <= 1'b0;
			end
		end else if (cmd.arm) begin
			active_q[slot] <= 1'b1;
		end else if (cmd.clear) begin
			active_q[slot] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.arm) begin
			deadline_q[slot] <= now_ms + budget;
			last_q[slot]     <= now_ms;
		end else if (cmd.touch) begin
			last_q[slot] <= now_ms;
		end
	end

endmodule

// File: design/wkq_checker.sv
// wkq_checker: port-level assertions for watchdog_kick_qualifier_core,
// attached by bind. Depends on wkq_pkg.
module wkq_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [2:0]                  kind,
	input  logic                        done,
	input  logic                        kick,
	input  logic                        guard_ok,
	input  logic [wkq_pkg::DEPTH_W-1:0] open_guards
);

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted item produced no result");

	a_depth_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(open_guards))
		else $error("depth moved without a result");

	a_startup_kick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == wkq_pkg::KIND_STARTUP |=> ##1 (done && kick))
		else $error("startup item did not kick");

	a_ok_kind: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind != wkq_pkg::KIND_PROGRESS |=> ##1 !guard_ok)
		else $error("guard_ok on a non-progress item");

endmodule

bind watchdog_kick_qualifier_core wkq_checker u_wkq_checker (.*);
